[rtl/tebt_pkg.sv]
// Shared types and codes for the tick encoder button timer.
package tebt_pkg;

    // Item opcodes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_WR_DELAY  = 3'd1;
    localparam logic [2:0] OP_WR_ANIM   = 3'd2;
    localparam logic [2:0] OP_WR_MIN    = 3'd3;
    localparam logic [2:0] OP_WR_SUBMIN = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRESS  = 2'd0;
    localparam logic [1:0] CFG_LONG   = 2'd1;
    localparam logic [1:0] CFG_RELOAD = 2'd2;

    // Configuration reset values
    localparam logic [15:0] PRESS_RST  = 16'd50;
    localparam logic [15:0] LONG_RST   = 16'd1000;
    localparam logic [15:0] RELOAD_RST = 16'd60000;

    // Button states
    localparam logic [1:0] BTN_RELEASED = 2'd0;
    localparam logic [1:0] BTN_SHORT    = 2'd1;
    localparam logic [1:0] BTN_LONG     = 2'd2;

    // Per-request control to the counter block
    typedef struct packed {
        logic       tick;
        logic       wr_delay;
        logic       wr_anim;
        logic       wr_min;
        logic       wr_sub;
        logic [1:0] enc_phase;
    } t_cnt_ctl;

    // Per-request control to the button block
    typedef struct packed {
        logic tick;
        logic held;
        logic clear;
    } t_btn_ctl;

    // One result snapshot
    typedef struct packed {
        logic        [15:0] delay_left;
        logic        [15:0] anim_left;
        logic        [15:0] minutes_remaining;
        logic        [15:0] subminute_left;
        logic signed [15:0] position;
        logic        [1:0]  button_result;
    } t_result;

endpackage

[rtl/tebt_counters.sv]
// Countdowns, minute timer and quadrature position counter.
module tebt_counters #(
    parameter int COUNT_WIDTH = 16,
    parameter int POS_WIDTH   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tebt_pkg::t_cnt_ctl     i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_value,
    input  logic [COUNT_WIDTH-1:0] i_reload,
    output logic [COUNT_WIDTH-1:0] o_delay,
    output logic [COUNT_WIDTH-1:0] o_anim,
    output logic [COUNT_WIDTH-1:0] o_min,
    output logic [COUNT_WIDTH-1:0] o_sub,
    output logic [POS_WIDTH-1:0]   o_pos
);
    import tebt_pkg::*;

    logic [COUNT_WIDTH-1:0] r_delay, n_delay;
    logic [COUNT_WIDTH-1:0] r_anim, n_anim;
    logic [COUNT_WIDTH-1:0] r_min, n_min;
    logic [COUNT_WIDTH-1:0] r_sub, n_sub;
    logic [POS_WIDTH-1:0]   r_pos, n_pos;
    logic [1:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] sub_dec;

    // Next state for one request
    always_comb begin
        n_delay = r_delay;
        n_anim  = r_anim;
        n_min   = r_min;
        n_sub   = r_sub;
        n_pos   = r_pos;
        n_phase = r_phase;
        sub_dec = r_sub - 1'b1;
        if (i_ctl.tick) begin
            if (r_delay != '0) n_delay = r_delay - 1'b1;
            if (r_anim != '0) n_anim = r_anim - 1'b1;
            // quadrature: count on entry to phase 0
            n_phase = i_ctl.enc_phase;
            if (i_ctl.enc_phase == 2'd0) begin
                if (r_phase == 2'd1) n_pos = r_pos - 1'b1;
                if (r_phase == 2'd2) n_pos = r_pos + 1'b1;
            end
            // minute timer
            if (r_min != '0 && r_sub != '0) begin
                if (sub_dec == '0) begin
                    n_sub = i_reload;
                    n_min = r_min - 1'b1;
                end else begin
                    n_sub = sub_dec;
                end
            end
        end
        if (i_ctl.wr_delay) n_delay = i_value;
        if (i_ctl.wr_anim) n_anim = i_value;
        if (i_ctl.wr_min) n_min = i_value;
        if (i_ctl.wr_sub) n_sub = i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_anim  <= '0;
            r_min   <= '0;
            r_sub   <= '0;
            r_pos   <= '0;
            r_phase <= 2'd0;
        end else begin
            r_delay <= n_delay;
            r_anim  <= n_anim;
            r_min   <= n_min;
            r_sub   <= n_sub;
            r_pos   <= n_pos;
            r_phase <= n_phase;
        end
    end

    assign o_delay = n_delay;
    assign o_anim  = n_anim;
    assign o_min   = n_min;
    assign o_sub   = n_sub;
    assign o_pos   = n_pos;

endmodule

[rtl/tebt_button.sv]
// Push button hold counter with press and long press detection.
module tebt_button #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tebt_pkg::t_btn_ctl i_ctl,
    input  logic [15:0]        i_press_thr,
    input  logic [15:0]        i_long_thr,
    output logic [1:0]         o_phase
);
    import tebt_pkg::*;

    localparam int BW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int NW = BW + 1;
    localparam logic [NW-1:0] CNT_MAX = {{(NW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

    logic [COUNT_WIDTH-1:0] r_hold, n_hold;
    logic [1:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] hold_base;
    logic [1:0]             phase_base;
    logic [NW-1:0]          hold_ext;
    logic [NW-1:0]          hold_inc;
    logic [NW-1:0]          press_ext;
    logic [NW-1:0]          long_ext;

    assign press_ext = NW'(i_press_thr);
    assign long_ext  = NW'(i_long_thr);

    // Clear first, then hold or release handling
    always_comb begin
        hold_base  = i_ctl.clear ? '0 : r_hold;
        phase_base = i_ctl.clear ? BTN_RELEASED : r_phase;
        hold_ext   = NW'(hold_base);
        hold_inc   = hold_ext + 1'b1;
        n_hold     = r_hold;
        n_phase    = r_phase;
        if (i_ctl.tick) begin
            n_hold  = hold_base;
            n_phase = phase_base;
            if (i_ctl.held) begin
                if (hold_inc >= long_ext) begin
                    n_phase = BTN_LONG;
                    if (hold_inc > long_ext) hold_inc = long_ext;
                end
                if (hold_inc > CNT_MAX) hold_inc = CNT_MAX;
                n_hold = hold_inc[COUNT_WIDTH-1:0];
            end else if (hold_ext >= press_ext) begin
                n_phase = BTN_SHORT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '0;
            r_phase <= BTN_RELEASED;
        end else begin
            r_hold  <= n_hold;
            r_phase <= n_phase;
        end
    end

    assign o_phase = n_phase;

endmodule

[rtl/tebt_out_buf.sv]
// Two-entry output register with skid stage for result snapshots.
module tebt_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tebt_pkg::t_result i_data,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output tebt_pkg::t_result o_data
);
    import tebt_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop        = r_main_valid && i_ready;
    assign o_can_push = !r_skid_valid;

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

[rtl/tick_encoder_button_timer_top.sv]
// Top level of the tick encoder button timer.
//
// Input channel (i_in_valid / o_in_ready): each request is a tick or a write
// of one counter, chosen by i_opcode. Every accepted request yields one result
// on the output channel (o_out_valid / i_out_ready): a snapshot of all
// counters, the encoder position and the button state after that request.
// The state updates at the accepting edge, and the snapshot is registered into the
// output buffer at that same edge. Throughput is one request per cycle while
// o_in_ready is high; the state registers update in a single pass of short logic.
// Results pass through an output register and a skid stage, so a request is
// still taken while one result waits; o_in_ready drops only when both hold
// results, and returns as soon as the receiver takes one.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) sets the
// press and long press thresholds and the minute reload; it is always ready
// and unknown indexes are ignored.
// Reset (synchronous, i_rst_n low) zeroes all counters, opens the button,
// restores the default thresholds and reload, and empties the output buffer.
module tick_encoder_button_timer_top #(
    parameter int COUNT_WIDTH = 16,
    parameter int POS_WIDTH   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic               i_enc_a,
    input  logic               i_enc_b,
    input  logic               i_button_level,
    input  logic               i_clear_button,
    input  logic [15:0]        i_write_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_delay_left,
    output logic [15:0]        o_anim_left,
    output logic [15:0]        o_minutes_remaining,
    output logic [15:0]        o_subminute_left,
    output logic signed [15:0] o_position,
    output logic [1:0]         o_button_result
);
    import tebt_pkg::*;

    localparam int CE = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int PE = (POS_WIDTH > 16) ? POS_WIDTH : 16;

    logic [15:0]            r_press_thr;
    logic [15:0]            r_long_thr;
    logic [15:0]            r_reload;
    logic                   accept;
    t_cnt_ctl               cnt_ctl;
    t_btn_ctl               btn_ctl;
    logic [COUNT_WIDTH-1:0] wr_val;
    logic [COUNT_WIDTH-1:0] reload_val;
    logic [COUNT_WIDTH-1:0] n_delay, n_anim, n_min, n_sub;
    logic [POS_WIDTH-1:0]   n_pos;
    logic [1:0]             n_btn;
    logic [CE-1:0]          delay_ext, anim_ext, min_ext, sub_ext;
    logic [PE-1:0]          pos_ext;
    t_result                res_in;
    t_result                res_out;
    logic                   can_push;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_thr <= PRESS_RST;
            r_long_thr  <= LONG_RST;
            r_reload    <= RELOAD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRESS:  r_press_thr <= i_cfg_data;
                CFG_LONG:   r_long_thr  <= i_cfg_data;
                CFG_RELOAD: r_reload    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = can_push;
    assign accept     = i_in_valid && can_push;
    assign wr_val     = COUNT_WIDTH'(i_write_value);
    assign reload_val = COUNT_WIDTH'(r_reload);

    // Opcode decode
    always_comb begin
        cnt_ctl           = '0;
        cnt_ctl.enc_phase = {i_enc_b, i_enc_a};
        if (accept) begin
            unique case (i_opcode)
                OP_TICK:      cnt_ctl.tick     = 1'b1;
                OP_WR_DELAY:  cnt_ctl.wr_delay = 1'b1;
                OP_WR_ANIM:   cnt_ctl.wr_anim  = 1'b1;
                OP_WR_MIN:    cnt_ctl.wr_min   = 1'b1;
                OP_WR_SUBMIN: cnt_ctl.wr_sub   = 1'b1;
                default: ;
            endcase
        end
        btn_ctl.tick  = cnt_ctl.tick;
        btn_ctl.held  = i_button_level;
        btn_ctl.clear = i_clear_button;
    end

    tebt_counters #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .POS_WIDTH  (POS_WIDTH)
    ) u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .i_value (wr_val),
        .i_reload(reload_val),
        .o_delay (n_delay),
        .o_anim  (n_anim),
        .o_min   (n_min),
        .o_sub   (n_sub),
        .o_pos   (n_pos)
    );

    tebt_button #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_button (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (btn_ctl),
        .i_press_thr(r_press_thr),
        .i_long_thr (r_long_thr),
        .o_phase    (n_btn)
    );

    // Snapshot: low 16 bits of each counter
    assign delay_ext = CE'(n_delay);
    assign anim_ext  = CE'(n_anim);
    assign min_ext   = CE'(n_min);
    assign sub_ext   = CE'(n_sub);
    assign pos_ext   = PE'(n_pos);

    always_comb begin
        res_in.delay_left        = delay_ext[15:0];
        res_in.anim_left         = anim_ext[15:0];
        res_in.minutes_remaining = min_ext[15:0];
        res_in.subminute_left    = sub_ext[15:0];
        res_in.position          = pos_ext[15:0];
        res_in.button_result     = n_btn;
    end

    tebt_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (accept),
        .i_data    (res_in),
        .o_can_push(can_push),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (res_out)
    );

    assign o_delay_left        = res_out.delay_left;
    assign o_anim_left         = res_out.anim_left;
    assign o_minutes_remaining = res_out.minutes_remaining;
    assign o_subminute_left    = res_out.subminute_left;
    assign o_position          = res_out.position;
    assign o_button_result     = res_out.button_result;

endmodule

[test/tick_encoder_button_timer_top_tb.sv]
// Self-checking testbench for the tick encoder button timer top level.
module tick_encoder_button_timer_top_tb;
    import tebt_pkg::*;

    // Opcodes and register index with no function in the block
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam logic [1:0] CFG_SPARE    = 2'd3;

    // Quadrature phases that move the position
    localparam logic [1:0] PH_REST = 2'd0;
    localparam logic [1:0] PH_A    = 2'd1;
    localparam logic [1:0] PH_B    = 2'd2;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 64;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int PRESSURE_PHASE  = 4;
    localparam int TAIL_CYCLES     = 8;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  op;
        logic        enc_a;
        logic        enc_b;
        logic        held;
        logic        clr;
        logic [15:0] val;
        logic [1:0]  cfg_idx;
        bit          typed;
        t_result     want;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_opcode;
    logic               i_enc_a;
    logic               i_enc_b;
    logic               i_button_level;
    logic               i_clear_button;
    logic [15:0]        i_write_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [15:0]        o_delay_left;
    logic [15:0]        o_anim_left;
    logic [15:0]        o_minutes_remaining;
    logic [15:0]        o_subminute_left;
    logic signed [15:0] o_position;
    logic [1:0]         o_button_result;

    tick_encoder_button_timer_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_enc_a             (i_enc_a),
        .i_enc_b             (i_enc_b),
        .i_button_level      (i_button_level),
        .i_clear_button      (i_clear_button),
        .i_write_value       (i_write_value),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_delay_left        (o_delay_left),
        .o_anim_left         (o_anim_left),
        .o_minutes_remaining (o_minutes_remaining),
        .o_subminute_left    (o_subminute_left),
        .o_position          (o_position),
        .o_button_result     (o_button_result)
    );

    // Predictor copy of the configuration, reset values from the package
    logic [15:0] press_thr  = PRESS_RST;
    logic [15:0] long_thr   = LONG_RST;
    logic [15:0] min_reload = RELOAD_RST;

    // Predictor copy of the counters, encoder and button
    logic [15:0] m_delay = '0;
    logic [15:0] m_anim  = '0;
    logic [15:0] m_min   = '0;
    logic [15:0] m_sub   = '0;
    logic [1:0]  m_phase = PH_REST;
    logic [15:0] m_pos   = '0;
    logic [15:0] m_hold  = '0;
    logic [1:0]  m_btn   = BTN_RELEASED;

    t_result   snapshots_due[$];
    t_stim_row dir_rows[$];

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int cycle_count     = 0;
    int idle_pct        = 0;
    int stall_pct       = 0;
    bit hold_wanted     = 1'b0;
    bit hold_done       = 1'b0;

    // Random stimulus state: encoder walk position (Gray coded) and button level
    logic [1:0] enc_idx  = 2'd0;
    logic       btn_down = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("FAIL tick_encoder_button_timer_top");
        $finish;
    end

    // Snapshot the block should give after one request; advances the predictor
    function automatic t_result next_snapshot(input logic [2:0] op, input logic enc_a,
                                              input logic enc_b, input logic held,
                                              input logic clr, input logic [15:0] val);
        logic [1:0]  prev;
        logic [16:0] nxt;
        t_result     s;
        case (op)
            OP_TICK: begin
                if (m_delay != 16'd0) m_delay = m_delay - 16'd1;
                if (m_anim != 16'd0) m_anim = m_anim - 16'd1;
                // quadrature: only a return to rest moves the position
                prev    = m_phase;
                m_phase = {enc_b, enc_a};
                if (m_phase == PH_REST) begin
                    if (prev == PH_A) m_pos = m_pos - 16'd1;
                    if (prev == PH_B) m_pos = m_pos + 16'd1;
                end
                // button: clear first, then count or judge the release
                if (clr) begin
                    m_hold = '0;
                    m_btn  = BTN_RELEASED;
                end
                if (held) begin
                    nxt = {1'b0, m_hold} + 17'd1;
                    if (nxt >= {1'b0, long_thr}) begin
                        m_btn = BTN_LONG;
                        if (nxt > {1'b0, long_thr}) nxt = {1'b0, long_thr};
                    end
                    if (nxt > 17'h0FFFF) nxt = 17'h0FFFF;
                    m_hold = nxt[15:0];
                end else if (m_hold >= press_thr) begin
                    m_btn = BTN_SHORT;
                end
                // minute timer runs only with both counts nonzero
                if (m_min != 16'd0 && m_sub != 16'd0) begin
                    m_sub = m_sub - 16'd1;
                    if (m_sub == 16'd0) begin
                        m_sub = min_reload;
                        m_min = m_min - 16'd1;
                    end
                end
            end
            OP_WR_DELAY:  m_delay = val;
            OP_WR_ANIM:   m_anim  = val;
            OP_WR_MIN:    m_min   = val;
            OP_WR_SUBMIN: m_sub   = val;
            default: ;
        endcase
        s.delay_left        = m_delay;
        s.anim_left         = m_anim;
        s.minutes_remaining = m_min;
        s.subminute_left    = m_sub;
        s.position          = m_pos;
        s.button_result     = m_btn;
        return s;
    endfunction

    function automatic t_result snap(input logic [15:0] d, input logic [15:0] an,
                                     input logic [15:0] mi, input logic [15:0] su,
                                     input logic [15:0] po, input logic [1:0] bt);
        t_result s;
        s.delay_left        = d;
        s.anim_left         = an;
        s.minutes_remaining = mi;
        s.subminute_left    = su;
        s.position          = po;
        s.button_result     = bt;
        return s;
    endfunction

    function automatic t_stim_row item_row(input logic [2:0] op, input logic enc_a,
                                           input logic enc_b, input logic held,
                                           input logic clr, input logic [15:0] val,
                                           input bit typed, input t_result want);
        t_stim_row r;
        r.kind    = ROW_ITEM;
        r.op      = op;
        r.enc_a   = enc_a;
        r.enc_b   = enc_b;
        r.held    = held;
        r.clr     = clr;
        r.val     = val;
        r.cfg_idx = CFG_PRESS;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] idx, input logic [15:0] data);
        t_stim_row r;
        r         = item_row(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, data, 1'b0, '0);
        r.kind    = ROW_CFG;
        r.cfg_idx = idx;
        return r;
    endfunction

    // Offer one request after a random idle gap; queue its expected snapshot
    task automatic send_item(input logic [2:0] op, input logic enc_a, input logic enc_b,
                             input logic held, input logic clr, input logic [15:0] val,
                             input bit typed, input t_result want);
        t_result predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_enc_a        <= enc_a;
        i_enc_b        <= enc_b;
        i_button_level <= held;
        i_clear_button <= clr;
        i_write_value  <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = next_snapshot(op, enc_a, enc_b, held, clr, val);
        snapshots_due.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Stop offering and wait until every expected snapshot has come back
    task automatic drain_snapshots();
        i_in_valid <= 1'b0;
        while (snapshots_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        drain_snapshots();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PRESS:  press_thr  = data;
            CFG_LONG:   long_thr   = data;
            CFG_RELOAD: min_reload = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Mostly clean quadrature walks and button holds, with some jumps and clears
    task automatic send_random_item();
        logic [2:0]  op;
        logic [15:0] val;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 70) op = OP_TICK;
        else if (r < 96) op = 3'($urandom_range(OP_WR_DELAY, OP_WR_SUBMIN));
        else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if (op == OP_TICK) begin
            r = $urandom_range(0, 99);
            if (r < 40) enc_idx = enc_idx + 2'd1;
            else if (r < 80) enc_idx = enc_idx - 2'd1;
            else if (r >= 92) enc_idx = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 11) == 0) btn_down = !btn_down;
        end
        // small values keep the timer rolling over; full range hits every bit
        if ($urandom_range(0, 99) < 60) val = 16'($urandom_range(0, 12));
        else val = 16'($urandom_range(0, 16'hFFFF));
        send_item(op, enc_idx[1] ^ enc_idx[0], enc_idx[1], btn_down,
                  $urandom_range(0, 24) == 0, val, 1'b0, '0);
    endtask

    // Receiver: random stalls, plus one long hold-off in the pressure phase
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (snapshots_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual delay %0d pos %0d",
                         $time, o_delay_left, o_position);
                errors++;
            end else begin
                want = snapshots_due.pop_front();
                check_field("delay_left", want.delay_left, o_delay_left);
                check_field("anim_left", want.anim_left, o_anim_left);
                check_field("minutes_remaining", want.minutes_remaining, o_minutes_remaining);
                check_field("subminute_left", want.subminute_left, o_subminute_left);
                check_field("position", int'(want.position), int'(o_position));
                check_field("button_result", want.button_result, o_button_result);
                results_checked++;
            end
        end
    end

    // Stimulus
    initial begin
        logic [15:0] p_press;
        logic [15:0] p_long;
        logic [15:0] p_reload;
        int          dir_items;

        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PRESS;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_TICK;
        i_enc_a        = 1'b0;
        i_enc_b        = 1'b0;
        i_button_level = 1'b0;
        i_clear_button = 1'b0;
        i_write_value  = '0;

        // Directed rows: reset values, counter extremes, phase moves, spare opcodes
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 0, 16'h0000, 1,
                                    snap(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                         BTN_RELEASED)));
        dir_rows.push_back(item_row(OP_WR_DELAY, 0, 0, 0, 0, 16'hFFFF, 1,
                                    snap(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                         BTN_RELEASED)));
        dir_rows.push_back(item_row(OP_WR_ANIM, 0, 0, 0, 0, 16'hFFFF, 1,
                                    snap(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                                         BTN_RELEASED)));
        dir_rows.push_back(item_row(OP_WR_MIN, 0, 0, 0, 0, 16'hFFFF, 1,
                                    snap(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                                         BTN_RELEASED)));
        dir_rows.push_back(item_row(OP_WR_SUBMIN, 0, 0, 0, 0, 16'h0001, 1,
                                    snap(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000,
                                         BTN_RELEASED)));
        // minute rollover reloads the default 60000
        dir_rows.push_back(item_row(OP_TICK, 1, 0, 0, 0, 16'h0000, 1,
                                    snap(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'd60000, 16'h0000,
                                         BTN_RELEASED)));
        // back to rest from phase A: position wraps below zero
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 0, 16'h0000, 1,
                                    snap(16'hFFFD, 16'hFFFD, 16'hFFFE, 16'd59999, 16'hFFFF,
                                         BTN_RELEASED)));
        dir_rows.push_back(item_row(OP_SPARE_LO, 1, 1, 1, 1, 16'h1234, 1,
                                    snap(16'hFFFD, 16'hFFFD, 16'hFFFE, 16'd59999, 16'hFFFF,
                                         BTN_RELEASED)));
        dir_rows.push_back(item_row(OP_SPARE_MID, 0, 1, 0, 1, 16'hFFFF, 0, '0));
        dir_rows.push_back(item_row(OP_SPARE_HI, 1, 0, 1, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 0, 1, 0, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 1, 1, 1, 0, 16'h0000, 0, '0));
        // subminute zero with minutes left: timer stands still
        dir_rows.push_back(item_row(OP_WR_SUBMIN, 0, 0, 0, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 1, 1, 1, 1, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 1, 1, 0, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_WR_MIN, 0, 0, 0, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_WR_SUBMIN, 0, 0, 0, 0, 16'hFFFF, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 1, 0, 16'h0000, 0, '0));
        // zero thresholds and reload, plus a write to the spare index
        dir_rows.push_back(cfg_row(CFG_PRESS, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_LONG, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_RELOAD, 16'h0000));
        dir_rows.push_back(cfg_row(CFG_SPARE, 16'hFFFF));
        // held count above the lowered long threshold clamps; release reverts to pressed
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 1, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 0, 16'h0000, 0, '0));
        // rollover with zero reload leaves the timer idle
        dir_rows.push_back(item_row(OP_WR_MIN, 0, 0, 0, 0, 16'h0002, 0, '0));
        dir_rows.push_back(item_row(OP_WR_SUBMIN, 0, 0, 0, 0, 16'h0001, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 0, 16'h0000, 0, '0));
        dir_rows.push_back(item_row(OP_TICK, 0, 0, 0, 1, 16'h0000, 0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].val);
            end else begin
                send_item(dir_rows[i].op, dir_rows[i].enc_a, dir_rows[i].enc_b,
                          dir_rows[i].held, dir_rows[i].clr, dir_rows[i].val,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end
        dir_items = items_sent;

        // Random part: one configuration and one idle/stall mix per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            p_press  = 16'($urandom_range(0, 10));
            p_long   = 16'($urandom_range(0, 25));
            p_reload = 16'($urandom_range(0, 6));
            case (ph)
                1: begin
                    p_press  = 16'hFFFF;
                    p_long   = 16'hFFFF;
                    p_reload = 16'hFFFF;
                end
                2: begin
                    p_press  = 16'd1;
                    p_long   = 16'd1;
                    p_reload = 16'd1;
                end
                default: ;
            endcase
            write_reg(CFG_PRESS, p_press);
            write_reg(CFG_LONG, p_long);
            write_reg(CFG_RELOAD, p_reload);
            write_reg(CFG_SPARE, 16'($urandom_range(0, 16'hFFFF)));
            case (ph)
                1: begin
                    idle_pct  = 70;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 70;
                end
                3: begin
                    idle_pct  = 21;
                    stall_pct = 21;
                end
                default: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            // receiver holds off while requests keep coming, so the block backs up
            if (ph == PRESSURE_PHASE) hold_wanted = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        // Wind down
        drain_snapshots();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (snapshots_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, snapshots_due.size());
            errors++;
        end

        $display("Covered %0d requests (%0d directed) and %0d register writes over %0d mixes",
                 items_sent, dir_items, cfg_writes, NUM_PHASES);
        $display("Checked %0d snapshots, %0d errors, %0d-cycle receiver hold-off",
                 results_checked, errors, HOLD_CYCLES);
        if (errors == 0) begin
            $display("PASS tick_encoder_button_timer_top");
        end else begin
            $display("FAIL tick_encoder_button_timer_top");
        end
        $finish;
    end

endmodule

[tick_encoder_button_timer_top.f]
rtl/tebt_pkg.sv
rtl/tebt_counters.sv
rtl/tebt_button.sv
rtl/tebt_out_buf.sv
rtl/tick_encoder_button_timer_top.sv
test/tick_encoder_button_timer_top_tb.sv
